FILE: rtl/core/bpdc_pkg.sv
// Shared types and constants for the button press duration classifier.
`timescale 1ns / 1ps

package bpdc_pkg;

  localparam int unsigned NumButtonsDefault = 3;
  localparam int unsigned MaxButtons        = 8;

  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned LevelWidth  = 3;
  localparam int unsigned ThrWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [ThrWidth-1:0] LongThrReset      = 16'd700;
  localparam logic [ThrWidth-1:0] SuperlongThrReset = 16'd3000;
  localparam logic                PressedLevelReset = 1'b1;

  typedef logic [TimeWidth-1:0]   time_t;
  typedef logic [LevelWidth-1:0]  levels_t;
  typedef logic [ThrWidth-1:0]    thr_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t RegLongThr      = 2'd0;
  localparam cfg_idx_t RegSuperlongThr = 2'd1;
  localparam cfg_idx_t RegPressedLevel = 2'd2;

  typedef enum logic [1:0] {
    STAGE_RELEASED  = 2'd0,
    STAGE_PRESSED   = 2'd1,
    STAGE_LONG      = 2'd2,
    STAGE_SUPERLONG = 2'd3
  } stage_e;

  typedef enum logic [2:0] {
    EV_NONE              = 3'd0,
    EV_PRESS             = 3'd1,
    EV_RELEASE           = 3'd2,
    EV_LONG              = 3'd3,
    EV_LONG_RELEASE      = 3'd4,
    EV_SUPERLONG         = 3'd5,
    EV_SUPERLONG_RELEASE = 3'd6
  } event_e;

endpackage

FILE: rtl/core/bpdc_if.sv
// Channel interfaces for sample requests, event results and register writes.
`timescale 1ns / 1ps

interface bpdc_in_if;
  logic                      valid;
  logic                      ready;
  bpdc_pkg::time_t           now_ms;
  bpdc_pkg::levels_t         button_levels;

  modport source (output valid, now_ms, button_levels, input ready);
  modport sink   (input valid, now_ms, button_levels, output ready);
endinterface

interface bpdc_out_if;
  logic                      valid;
  logic                      ready;
  bpdc_pkg::event_e          event_button0;
  bpdc_pkg::event_e          event_button1;
  bpdc_pkg::event_e          event_button2;
  logic                      any_activity;

  modport source (output valid, event_button0, event_button1, event_button2, any_activity,
                  input ready);
  modport sink   (input valid, event_button0, event_button1, event_button2, any_activity,
                  output ready);
endinterface

interface bpdc_cfg_if;
  logic                      valid;
  logic                      ready;
  bpdc_pkg::cfg_idx_t        index;
  bpdc_pkg::thr_t            wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: rtl/core/button_press_duration_classifier.sv
// Top level of the button press duration classifier.
`timescale 1ns / 1ps

// Each request on in_i is one sample tick: the current time in milliseconds
// (wrapping modulo 2^32) and the raw level of up to three buttons. Every
// tracked button walks released -> pressed -> long -> superlong, one step per
// tick at most; a long step needs (now - press start) > long threshold and a
// superlong step needs the same elapsed time > superlong threshold, both
// measured from the moment the press began. Each tick returns exactly one
// result on out_o with an event code per button and an any_activity flag.
// Rate: one tick per clock while out_o accepts results. A request lands in an
// input register; when it advances, the per-button trackers update and the
// result register loads. The only limit is the result register, which stalls
// the input register when out_o backpressures. Buttons beyond the third
// (NUM_BUTTONS up to 8) read level 0, are tracked and count toward
// any_activity, but have no event field. Register writes on cfg_i are always
// taken and must arrive while no tick is in flight; an index outside the list
// is dropped.
module button_press_duration_classifier #(
  parameter int unsigned NUM_BUTTONS = bpdc_pkg::NumButtonsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpdc_in_if.sink     in_i,
  bpdc_out_if.source  out_o,
  bpdc_cfg_if.sink    cfg_i
);

  localparam int unsigned NumFields = 3;

  // Configuration registers
  bpdc_pkg::thr_t long_thr_q, superlong_thr_q;
  logic           pressed_level_q;

  // Input register
  logic              in_valid_q, in_valid_d;
  bpdc_pkg::time_t   now_q;
  bpdc_pkg::levels_t levels_q;

  // Tracker state
  bpdc_pkg::stage_e stage_q [NUM_BUTTONS];
  bpdc_pkg::stage_e stage_d [NUM_BUTTONS];
  bpdc_pkg::time_t  start_q [NUM_BUTTONS];
  logic             start_we [NUM_BUTTONS];
  bpdc_pkg::event_e ev      [NUM_BUTTONS];

  // Result register
  logic             out_valid_q, out_valid_d;
  bpdc_pkg::event_e field_ev_d [NumFields];
  bpdc_pkg::event_e field_ev_q [NumFields];
  logic             any_d, any_q;

  logic in_take, out_take, advance;

  // Handshakes: advance the held tick when the result slot is free or draining.
  assign out_take = out_valid_q && out_o.ready;
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  // Per-button tracker: one transition per tick, first match wins.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    logic            lvl;
    logic            down;
    bpdc_pkg::time_t elapsed;
    logic            long_hit, superlong_hit;

    // Buttons past the input field read a constant low level.
    if (i < bpdc_pkg::LevelWidth) begin : g_lvl
      assign lvl = levels_q[i];
    end else begin : g_nolvl
      assign lvl = 1'b0;
    end

    assign down          = (lvl == pressed_level_q);
    assign elapsed       = now_q - start_q[i];
    assign long_hit      = elapsed > {{(bpdc_pkg::TimeWidth - bpdc_pkg::ThrWidth){1'b0}},
                                      long_thr_q};
    assign superlong_hit = elapsed > {{(bpdc_pkg::TimeWidth - bpdc_pkg::ThrWidth){1'b0}},
                                      superlong_thr_q};

    always_comb begin
      stage_d[i]  = stage_q[i];
      start_we[i] = 1'b0;
      ev[i]       = bpdc_pkg::EV_NONE;
      unique case (stage_q[i])
        bpdc_pkg::STAGE_RELEASED: begin
          if (down) begin
            stage_d[i]  = bpdc_pkg::STAGE_PRESSED;
            start_we[i] = 1'b1;
            ev[i]       = bpdc_pkg::EV_PRESS;
          end
        end
        bpdc_pkg::STAGE_PRESSED: begin
          if (!down) begin
            stage_d[i] = bpdc_pkg::STAGE_RELEASED;
            ev[i]      = bpdc_pkg::EV_RELEASE;
          end else if (long_hit) begin
            stage_d[i] = bpdc_pkg::STAGE_LONG;
            ev[i]      = bpdc_pkg::EV_LONG;
          end
        end
        bpdc_pkg::STAGE_LONG: begin
          if (!down) begin
            stage_d[i] = bpdc_pkg::STAGE_RELEASED;
            ev[i]      = bpdc_pkg::EV_LONG_RELEASE;
          end else if (superlong_hit) begin
            stage_d[i] = bpdc_pkg::STAGE_SUPERLONG;
            ev[i]      = bpdc_pkg::EV_SUPERLONG;
          end
        end
        bpdc_pkg::STAGE_SUPERLONG: begin
          if (!down) begin
            stage_d[i] = bpdc_pkg::STAGE_RELEASED;
            ev[i]      = bpdc_pkg::EV_SUPERLONG_RELEASE;
          end
        end
      endcase
    end

    // Press start time needs no reset: it is written on every press.
    always_ff @(posedge clk_i) begin
      if (advance && start_we[i]) begin
        start_q[i] <= now_q;
      end
    end
  end

  // Map trackers onto the fixed event fields; missing buttons report none.
  for (genvar k = 0; k < NumFields; k++) begin : g_field
    if (k < NUM_BUTTONS) begin : g_used
      assign field_ev_d[k] = ev[k];
    end else begin : g_unused
      assign field_ev_d[k] = bpdc_pkg::EV_NONE;
    end
  end

  // Activity covers every tracked button, including those without a field.
  always_comb begin
    any_d = 1'b0;
    for (int unsigned b = 0; b < NUM_BUTTONS; b++) begin
      if (ev[b] != bpdc_pkg::EV_NONE) begin
        any_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_thr_q      <= bpdc_pkg::LongThrReset;
      superlong_thr_q <= bpdc_pkg::SuperlongThrReset;
      pressed_level_q <= bpdc_pkg::PressedLevelReset;
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      for (int unsigned b = 0; b < NUM_BUTTONS; b++) begin
        stage_q[b] <= bpdc_pkg::STAGE_RELEASED;
      end
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          bpdc_pkg::RegLongThr:      long_thr_q      <= cfg_i.wdata;
          bpdc_pkg::RegSuperlongThr: superlong_thr_q <= cfg_i.wdata;
          bpdc_pkg::RegPressedLevel: pressed_level_q <= cfg_i.wdata[0];
          default: ;
        endcase
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        for (int unsigned b = 0; b < NUM_BUTTONS; b++) begin
          stage_q[b] <= stage_d[b];
        end
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q    <= in_i.now_ms;
      levels_q <= in_i.button_levels;
    end
    if (advance) begin
      for (int unsigned k = 0; k < NumFields; k++) begin
        field_ev_q[k] <= field_ev_d[k];
      end
      any_q <= any_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_button0 = field_ev_q[0];
  assign out_o.event_button1 = field_ev_q[1];
  assign out_o.event_button2 = field_ev_q[2];
  assign out_o.any_activity  = any_q;

  // A released button can only move to pressed.
  a_no_skip_from_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q[0] == bpdc_pkg::STAGE_RELEASED |=>
      stage_q[0] == bpdc_pkg::STAGE_RELEASED || stage_q[0] == bpdc_pkg::STAGE_PRESSED)
    else $error("button 0 left released without passing through pressed");

  // Tracker state moves only when a tick is processed.
  a_stage_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(stage_q[0]))
    else $error("tracker stage changed without a processed tick");

  // An empty result slot never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled while result register is empty");

  // A shown event implies the activity flag.
  a_activity_covers_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !any_q |-> field_ev_q[0] == bpdc_pkg::EV_NONE &&
      field_ev_q[1] == bpdc_pkg::EV_NONE && field_ev_q[2] == bpdc_pkg::EV_NONE)
    else $error("event reported without activity flag");

endmodule
